@@ hdl/tmsrgb_pkg.sv @@
// Shared constants, types and tables for the tone map and sRGB encode core.
package tmsrgb_pkg;

	localparam int INPUT_WIDTH = 20;

	// Exponent argument width: Q.30 values below 32.0.
	localparam int X_W = 35;

	// Pipeline shape of one channel.
	localparam int DIV_N   = 7;
	localparam int LOG_N   = 30;
	localparam int EXP_LAT = 40;
	localparam int CH_LAT  = 2 * EXP_LAT + DIV_N + LOG_N + 11;

	localparam logic [31:0] ONE_Q30  = 32'h4000_0000;
	localparam logic [31:0] LN2_Q30  = 32'd744261118;
	localparam logic [15:0] HALF_ONE = 16'd15360;

	typedef struct packed {
		logic        mode;
		logic [15:0] gain;
		logic [15:0] head;
	} cfg_t;

	// floor(2^32 / n) for the Taylor term divisors.
	function automatic logic [31:0] tmsrgb_recip(input int n);
		logic [31:0] r;
		case (n)
			2:       r = 32'd2147483648;
			3:       r = 32'd1431655765;
			4:       r = 32'd1073741824;
			5:       r = 32'd858993459;
			6:       r = 32'd715827882;
			7:       r = 32'd613566756;
			8:       r = 32'd536870912;
			9:       r = 32'd477218588;
			10:      r = 32'd429496729;
			11:      r = 32'd390451572;
			12:      r = 32'd357913941;
			default: r = 32'd0;
		endcase
		return r;
	endfunction

endpackage

@@ hdl/tmsrgb_exp.sv @@
// Pipelined exp(-x) in Q.30: truncated Taylor series on x/32, then five squarings.
module tmsrgb_exp
	import tmsrgb_pkg::*;
(
	input  logic           clk,
	input  logic [X_W-1:0] x,
	input  logic           big,
	output logic [30:0]    e
);

	logic [29:0] y_s    [1:12];
	logic [29:0] term_s [1:12];
	logic [31:0] pos_s  [1:12];
	logic [31:0] neg_s  [1:12];
	logic        z_s    [1:12];

	logic [29:0] pa_s   [2:12];
	logic [29:0] ya_s   [2:12];
	logic [31:0] posa_s [2:12];
	logic [31:0] nega_s [2:12];
	logic        za_s   [2:12];

	logic [29:0] q0_s   [2:12];
	logic [29:0] pb_s   [2:12];
	logic [29:0] yb_s   [2:12];
	logic [31:0] posb_s [2:12];
	logic [31:0] negb_s [2:12];
	logic        zb_s   [2:12];

	logic [30:0] r_s  [0:5];
	logic        zd_s [0:5];

	// The first term is y itself.
	always_ff @(posedge clk) begin
		y_s[1]    <= x[34:5];
		term_s[1] <= x[34:5];
		pos_s[1]  <= ONE_Q30;
		neg_s[1]  <= {2'b00, x[34:5]};
		z_s[1]    <= big;
	end

	for (genvar n = 2; n <= 12; n++) begin : g_term
		localparam logic [31:0] RC = tmsrgb_recip(n);
		logic [59:0] pr_a;
		logic [61:0] pr_b;
		logic [33:0] qn;
		logic [29:0] rem;
		logic [29:0] q;

		assign pr_a = 60'(term_s[n-1]) * 60'(y_s[n-1]);

		always_ff @(posedge clk) begin
			pa_s[n]   <= pr_a[59:30];
			ya_s[n]   <= y_s[n-1];
			posa_s[n] <= pos_s[n-1];
			nega_s[n] <= neg_s[n-1];
			za_s[n]   <= z_s[n-1];
		end

		assign pr_b = 62'(pa_s[n]) * 62'(RC);

		always_ff @(posedge clk) begin
			q0_s[n]   <= pr_b[61:32];
			pb_s[n]   <= pa_s[n];
			yb_s[n]   <= ya_s[n];
			posb_s[n] <= posa_s[n];
			negb_s[n] <= nega_s[n];
			zb_s[n]   <= za_s[n];
		end

		// The reciprocal estimate is at most one low.
		assign qn  = 34'(q0_s[n]) * 34'(n);
		assign rem = pb_s[n] - qn[29:0];
		assign q   = (rem >= 30'(n)) ? q0_s[n] + 30'd1 : q0_s[n];

		always_ff @(posedge clk) begin
			term_s[n] <= q;
			y_s[n]    <= yb_s[n];
			z_s[n]    <= zb_s[n];
			if (n % 2 == 1) begin
				neg_s[n] <= negb_s[n] + 32'(q);
				pos_s[n] <= posb_s[n];
			end else begin
				pos_s[n] <= posb_s[n] + 32'(q);
				neg_s[n] <= negb_s[n];
			end
		end
	end

	always_ff @(posedge clk) begin
		r_s[0]  <= (pos_s[12] > neg_s[12]) ? 31'(pos_s[12] - neg_s[12]) : 31'd0;
		zd_s[0] <= z_s[12];
	end

	for (genvar j = 1; j <= 5; j++) begin : g_sq
		logic [62:0] sq;
		assign sq = 63'(r_s[j-1]) * 63'(r_s[j-1]) + 63'h2000_0000;
		always_ff @(posedge clk) begin
			r_s[j]  <= sq[60:30];
			zd_s[j] <= zd_s[j-1];
		end
	end

	assign e = zd_s[5] ? 31'd0 : r_s[5];

endmodule

@@ hdl/tmsrgb_chan.sv @@
// One color channel: exposure, roll-off, and sRGB byte or half-float encode.
module tmsrgb_chan
	import tmsrgb_pkg::*;
(
	input  logic                   clk,
	input  cfg_t                   cfg,
	input  logic [INPUT_WIDTH-1:0] din,
	output logic [15:0]            dout
);

	localparam int ST_E  = 2 + DIV_N + EXP_LAT;
	localparam int ST_S1 = ST_E + 2;
	localparam int ST_B1 = ST_S1 + LOG_N + 5 + EXP_LAT + 1;

	typedef struct packed {
		logic        lin_seg;
		logic [7:0]  sb;
		logic [15:0] half;
	} side_t;

	function automatic logic [20:0] div_step5(input logic [15:0] r, input logic [4:0] b,
			input logic [15:0] d);
		logic [16:0] w;
		logic [15:0] rr;
		logic [4:0]  q;
		rr = r;
		q  = '0;
		for (int i = 4; i >= 0; i--) begin
			w = {rr, b[i]};
			if (w >= {1'b0, d}) begin
				rr   = 16'(w - {1'b0, d});
				q[i] = 1'b1;
			end else begin
				rr = w[15:0];
			end
		end
		return {rr, q};
	endfunction

	function automatic logic [15:0] half_enc(input logic [20:0] t);
		logic [4:0]  p;
		logic [4:0]  sh;
		logic [20:0] mw;
		logic [20:0] remv;
		logic [20:0] hw;
		logic [15:0] h;
		p = '0;
		for (int i = 0; i < 21; i++) begin
			if (t[i]) p = 5'(i);
		end
		if (t < 21'd4) begin
			h = {6'd0, t[1:0], 8'd0};
		end else begin
			if (p >= 5'd10) begin
				sh   = p - 5'd10;
				mw   = t >> sh;
				remv = t & ((21'd1 << sh) - 21'd1);
				hw   = (sh == 5'd0) ? 21'd0 : (21'd1 << (sh - 5'd1));
				if (sh != 5'd0 && (remv > hw || (remv == hw && mw[0]))) begin
					mw = mw + 21'd1;
				end
			end else begin
				mw = t << (5'd10 - p);
			end
			h = ({11'd0, p - 5'd1} << 10) + mw[15:0] - 16'd1024;
		end
		return h;
	endfunction

	logic [15:0] hd;
	logic [15:0] hm;

	assign hd = cfg.mode ? ((cfg.head < 16'd41) ? 16'd41 : cfg.head) : 16'd4096;
	assign hm = cfg.mode ? cfg.head : 16'd4096;

	// Exposure with saturation.
	logic [INPUT_WIDTH+15:0] mul;
	logic [63:0]             vw;
	logic [31:0]             v_s1;

	assign mul = din * cfg.gain;
	assign vw  = (64'(mul) + 64'd2048) >> 12;

	always_ff @(posedge clk) begin
		v_s1 <= (|vw[63:32]) ? 32'hFFFF_FFFF : vw[31:0];
	end

	// Divider x = v * 2^26 / hd, five quotient bits per stage.
	logic [15:0] dr_s [0:DIV_N];
	logic [34:0] dl_s [0:DIV_N];
	logic [34:0] dq_s [0:DIV_N];
	logic        db_s [0:DIV_N];
	logic [11:0] pd_s [2:ST_E];

	always_ff @(posedge clk) begin
		db_s[0] <= v_s1 >= {7'd0, hd, 9'd0};
		dr_s[0] <= v_s1[24:9];
		dl_s[0] <= {v_s1[8:0], 26'd0};
		dq_s[0] <= '0;
		pd_s[2] <= {v_s1 <= 32'd1310, v_s1[10:0]};
	end

	for (genvar k = 1; k <= DIV_N; k++) begin : g_div
		logic [20:0] st;
		assign st = div_step5(dr_s[k-1], dl_s[k-1][34:30], hd);
		always_ff @(posedge clk) begin
			dr_s[k] <= st[20:5];
			dl_s[k] <= {dl_s[k-1][29:0], 5'd0};
			dq_s[k] <= {dq_s[k-1][29:0], st[4:0]};
			db_s[k] <= db_s[k-1];
		end
	end

	for (genvar k = 3; k <= ST_E; k++) begin : g_pd
		always_ff @(posedge clk) begin
			pd_s[k] <= pd_s[k-1];
		end
	end

	logic [30:0] e1;

	tmsrgb_exp u_exp_roll (
		.clk (clk),
		.x   (dq_s[DIV_N]),
		.big (db_s[DIV_N]),
		.e   (e1)
	);

	// Roll-off output t = H * (1 - e), or the small value itself.
	logic [30:0] diff;
	logic [47:0] tp;
	logic [20:0] t_s;

	assign diff = 31'(ONE_Q30) - e1;
	assign tp   = 48'(hm) * 48'(diff) + (48'd1 << 25);

	always_ff @(posedge clk) begin
		t_s <= pd_s[ST_E][11] ? {10'd0, pd_s[ST_E][10:0]} : tp[46:26];
	end

	// Log stage setup and the short linear segment.
	logic [16:0] tc;
	logic [4:0]  lp;
	logic [24:0] sm;
	logic [15:0] sbp;

	assign tc  = (t_s > 21'd65536) ? 17'd65536 : t_s[16:0];
	assign sm  = 25'(tc[7:0]) * 25'd32946 + 25'd327680;
	assign sbp = 16'(sm[24:17]) * 16'd205;

	always_comb begin
		lp = '0;
		for (int i = 0; i < 17; i++) begin
			if (tc[i]) lp = 5'(i);
		end
	end

	logic [30:0] m_s  [0:LOG_N];
	logic [29:0] fr_s [0:LOG_N];
	logic [4:0]  p_s  [0:LOG_N];
	side_t       sd_s [ST_S1:ST_B1];

	always_ff @(posedge clk) begin
		m_s[0]        <= 31'(tc) << (5'd30 - lp);
		fr_s[0]       <= '0;
		p_s[0]        <= lp;
		sd_s[ST_S1]   <= '{lin_seg: tc <= 17'd205, sb: {2'b00, sbp[15:10]},
			half: half_enc(t_s)};
	end

	for (genvar k = ST_S1 + 1; k <= ST_B1; k++) begin : g_sd
		always_ff @(posedge clk) begin
			sd_s[k] <= sd_s[k-1];
		end
	end

	// Fraction bits of log2 by repeated squaring.
	for (genvar k = 1; k <= LOG_N; k++) begin : g_log
		logic [61:0] sq;
		assign sq = 62'(m_s[k-1]) * 62'(m_s[k-1]);
		always_ff @(posedge clk) begin
			m_s[k]  <= sq[61] ? sq[61:31] : sq[60:30];
			fr_s[k] <= {fr_s[k-1][28:0], sq[61]};
			p_s[k]  <= p_s[k-1];
		end
	end

	// y = floor(5l/12) * ln2, with the divide by three split in two halves.
	logic [34:0] lv;
	logic [37:0] l5;
	logic [34:0] la_s;
	logic [35:0] qh_pr;
	logic [16:0] qh_s;
	logic [34:0] la2_s;
	logic [19:0] q3;
	logic [17:0] rh;
	logic [18:0] b_s;
	logic [16:0] qh3_s;
	logic [37:0] qb_pr;
	logic [33:0] qq_s;
	logic [61:0] ym;
	logic [31:0] ly_s;

	assign lv    = 35'h4_0000_0000 - {p_s[LOG_N], fr_s[LOG_N]};
	assign l5    = 38'(lv) * 38'd5;
	assign qh_pr = 36'(la_s[34:17]) * 36'd174763;
	assign q3    = 20'(qh_s) * 20'd3;
	assign rh    = la2_s[34:17] - q3[17:0];
	assign qb_pr = 38'(b_s) * 38'd174763;
	assign ym    = 62'(qq_s[31:0]) * 62'(LN2_Q30);

	always_ff @(posedge clk) begin
		la_s  <= l5[36:2];
		qh_s  <= qh_pr[35:19];
		la2_s <= la_s;
		b_s   <= {rh[1:0], la2_s[16:0]};
		qh3_s <= qh_s;
		qq_s  <= {qh3_s, qb_pr[35:19]};
		ly_s  <= ym[61:30];
	end

	logic [30:0] e2;

	tmsrgb_exp u_exp_pow (
		.clk (clk),
		.x   (35'(ly_s)),
		.big (1'b0),
		.e   (e2)
	);

	// byte = (269.025 u - 14.025) rounded, with /1000 as /8 then /125.
	localparam logic [49:0] SUB_Q30 = 50'd13525 << 30;

	logic [49:0] w;
	logic [49:0] wd;
	logic [17:0] d_s;
	logic        nz_s;
	logic [31:0] bpr;
	logic [9:0]  bq;
	logic [7:0]  byte_v;
	logic [7:0]  srgb;
	logic [15:0] res_s;

	assign w  = 50'(e2) * 50'd269025;
	assign wd = w - SUB_Q30;

	always_ff @(posedge clk) begin
		d_s  <= wd[47:30];
		nz_s <= w > SUB_Q30;
	end

	assign bpr    = 32'(d_s[17:3]) * 32'd33555;
	assign bq     = bpr[31:22];
	assign byte_v = (bq > 10'd255) ? 8'd255 : bq[7:0];

	always_comb begin
		if (sd_s[ST_B1].lin_seg) begin
			srgb = sd_s[ST_B1].sb;
		end else if (!nz_s) begin
			srgb = 8'd0;
		end else begin
			srgb = byte_v;
		end
	end

	always_ff @(posedge clk) begin
		res_s <= cfg.mode ? sd_s[ST_B1].half : {8'd0, srgb};
	end

	assign dout = res_s;

endmodule

@@ hdl/pixel_tone_map_srgb_encode_core.sv @@
// Top level: configuration registers, three channel pipelines and the result strobe.
//
//  port group      direction  handshake               words
//  pixel in        in         start high, busy low    red_in, green_in, blue_in, end_of_frame
//  result out      out        strobe, one cycle       red_out, green_out, blue_out, alpha_out,
//                                                      frame_done
//  configuration   in/out     psel, penable, pwrite   output_mode 0x0, exposure_gain 0x4,
//                                                      headroom_level 0x8
//
// One word is taken every cycle; busy stays low.
// Each word passes through the two 40-stage exp pipelines, the 30-stage log2 squaring chain
// and the 7-stage divider on its way to the outputs.
// Reset clears the valid line and sets the registers to sRGB mode, gain 1.0, headroom 1.0.
// The receiver cannot stall, so the pipeline never holds.
module pixel_tone_map_srgb_encode_core
	import tmsrgb_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   psel,
	input  logic                   penable,
	input  logic                   pwrite,
	input  logic [3:0]             paddr,
	input  logic [31:0]            pwdata,
	output logic [31:0]            prdata,
	output logic                   pready,
	input  logic                   start,
	output logic                   busy,
	input  logic [INPUT_WIDTH-1:0] red_in,
	input  logic [INPUT_WIDTH-1:0] green_in,
	input  logic [INPUT_WIDTH-1:0] blue_in,
	input  logic                   end_of_frame,
	output logic                   strobe,
	output logic [15:0]            red_out,
	output logic [15:0]            green_out,
	output logic [15:0]            blue_out,
	output logic [15:0]            alpha_out,
	output logic                   frame_done
);

	localparam logic [1:0] REG_MODE = 2'd0;
	localparam logic [1:0] REG_GAIN = 2'd1;
	localparam logic [1:0] REG_HEAD = 2'd2;

	logic        mode_q;
	logic [15:0] gain_q;
	logic [15:0] head_q;
	logic        wr_en;
	cfg_t        cfg;

	assign pready = 1'b1;
	assign busy   = 1'b0;
	assign wr_en  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= 1'b0;
			gain_q <= 16'd4096;
			head_q <= 16'd4096;
		end else if (wr_en) begin
			case (paddr[3:2])
				REG_MODE: mode_q <= pwdata[0];
				REG_GAIN: gain_q <= pwdata[15:0];
				REG_HEAD: head_q <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			REG_MODE: prdata = {31'd0, mode_q};
			REG_GAIN: prdata = {16'd0, gain_q};
			REG_HEAD: prdata = {16'd0, head_q};
			default:  prdata = 32'd0;
		endcase
	end

	assign cfg = '{mode: mode_q, gain: gain_q, head: head_q};

	tmsrgb_chan u_red (
		.clk  (clk),
		.cfg  (cfg),
		.din  (red_in),
		.dout (red_out)
	);

	tmsrgb_chan u_green (
		.clk  (clk),
		.cfg  (cfg),
		.din  (green_in),
		.dout (green_out)
	);

	tmsrgb_chan u_blue (
		.clk  (clk),
		.cfg  (cfg),
		.din  (blue_in),
		.dout (blue_out)
	);

	// Valid and end-of-frame travel beside the channel data.
	logic vld_s [1:CH_LAT];
	logic eof_s [1:CH_LAT];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 1; i <= CH_LAT; i++) begin
				vld_s[i] <= 1'b0;
			end
		end else begin
			vld_s[1] <= start && !busy;
			for (int i = 2; i <= CH_LAT; i++) begin
				vld_s[i] <= vld_s[i-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		eof_s[1] <= end_of_frame;
		for (int i = 2; i <= CH_LAT; i++) begin
			eof_s[i] <= eof_s[i-1];
		end
	end

	assign strobe     = vld_s[CH_LAT];
	assign frame_done = eof_s[CH_LAT];
	assign alpha_out  = mode_q ? HALF_ONE : 16'd0;

endmodule

@@ tb/tb_pixel_tone_map_srgb_encode_core.sv @@
// Self-checking testbench for the tone map and sRGB/half encode core.
module tb_pixel_tone_map_srgb_encode_core
	import tmsrgb_pkg::*;
();
	timeunit 1ns;
	timeprecision 1ps;

	localparam int LATENCY   = CH_LAT + 20;
	localparam int WDOG_MAX  = 20000;
	localparam logic [3:0] ADDR_MODE = 4'h0;
	localparam logic [3:0] ADDR_GAIN = 4'h4;
	localparam logic [3:0] ADDR_HEAD = 4'h8;
	localparam logic MODE_SRGB = 1'b0;
	localparam logic MODE_HDR  = 1'b1;
	localparam logic [63:0] Q30_ONE = 64'd1 << 30;

	typedef struct packed {
		logic [INPUT_WIDTH-1:0] r;
		logic [INPUT_WIDTH-1:0] g;
		logic [INPUT_WIDTH-1:0] b;
		logic                   eof;
	} pixel_t;

	typedef struct packed {
		logic [15:0] r;
		logic [15:0] g;
		logic [15:0] b;
		logic [15:0] a;
		logic        eof;
	} tone_t;

	logic clk, arst_n;
	logic psel, penable, pwrite;
	logic [3:0] paddr;
	logic [31:0] pwdata, prdata;
	logic pready;
	logic start, busy;
	logic [INPUT_WIDTH-1:0] red_in, green_in, blue_in;
	logic end_of_frame;
	logic strobe;
	logic [15:0] red_out, green_out, blue_out, alpha_out;
	logic frame_done;

	pixel_tone_map_srgb_encode_core uut (.*);

	// Predictor copy of the registers.
	logic        mdl_mode;
	logic [15:0] mdl_gain;
	logic [15:0] mdl_head;

	pixel_t pixel_queue[$];
	tone_t  tone_queue[$];
	int     idle_pct;
	int     mismatches, accepted_in, accepted_out, wdog, hdr_words, srgb_words;
	bit     feed_on;

	function automatic logic [63:0] exp_neg(input logic [63:0] x);
		logic [63:0] y, term, pos, neg, r;
		if (x >= (64'd32 << 30))
			return 0;
		y = x >> 5;
		term = Q30_ONE;
		pos = Q30_ONE;
		neg = 0;
		for (int n = 1; n <= 12; n++) begin
			term = ((term * y) >> 30) / n;
			if (n % 2)
				neg += term;
			else
				pos += term;
		end
		r = (pos > neg) ? pos - neg : 0;
		for (int n = 0; n < 5; n++)
			r = (r * r + (Q30_ONE >> 1)) >> 30;
		return r;
	endfunction

	function automatic logic [63:0] neg_log2(input logic [31:0] t);
		int p;
		logic [63:0] m, frac;
		p = 0;
		frac = 0;
		while (p < 16 && (t >> (p + 1)) != 0)
			p++;
		m = 64'(t) << (30 - p);
		for (int i = 1; i <= 30; i++) begin
			m = (m * m) >> 30;
			if (m >= (Q30_ONE << 1)) begin
				m = m >> 1;
				frac |= 64'd1 << (30 - i);
			end
		end
		return (64'd16 << 30) - ((64'(p) << 30) + frac);
	endfunction

	function automatic logic [15:0] encode_srgb(input logic [31:0] t_in);
		logic [31:0] t;
		logic [63:0] l, y, u, num, sub, b;
		t = (t_in > 65536) ? 32'd65536 : t_in;
		if (t <= 205)
			return 16'((64'(t) * 32946 + 327680) / 655360);
		l = neg_log2(t);
		y = ((l * 5 / 12) * 64'(LN2_Q30)) >> 30;
		u = exp_neg(y);
		num = u * 269025 + (64'd500 << 30);
		sub = 64'd14025 << 30;
		if (num <= sub)
			return 0;
		b = (num - sub) / (64'd1000 << 30);
		return (b > 255) ? 16'd255 : 16'(b);
	endfunction

	function automatic logic [15:0] encode_half(input logic [31:0] t);
		int p;
		logic [31:0] m, rem, halfway, sh;
		if (t < 4)
			return 16'(t << 8);
		p = 0;
		while (p < 31 && (t >> (p + 1)) != 0)
			p++;
		if (p >= 10) begin
			sh = p - 10;
			m = t >> sh;
			if (sh > 0) begin
				rem = t & ((32'd1 << sh) - 1);
				halfway = 32'd1 << (sh - 1);
				if (rem > halfway || (rem == halfway && m[0]))
					m++;
			end
		end else begin
			m = t << (10 - p);
		end
		return 16'(((32'(p - 1)) << 10) + (m - 1024));
	endfunction

	function automatic logic [31:0] roll_off(input logic [INPUT_WIDTH-1:0] lin,
			input logic [31:0] mul, input logic [31:0] div);
		logic [63:0] v, x, e;
		v = (64'(lin) * mdl_gain + 2048) >> 12;
		if (v > 64'hFFFF_FFFF)
			v = 64'hFFFF_FFFF;
		if (v <= 1310)
			return 32'(v);
		x = (v << 26) / div;
		e = exp_neg(x);
		return 32'((64'(mul) * (Q30_ONE - e) + (64'd1 << 25)) >> 26);
	endfunction

	function automatic logic [15:0] map_channel(input logic [INPUT_WIDTH-1:0] lin);
		logic [31:0] hd;
		hd = (mdl_head < 41) ? 32'd41 : 32'(mdl_head);
		if (mdl_mode == MODE_HDR)
			return encode_half(roll_off(lin, 32'(mdl_head), hd));
		return encode_srgb(roll_off(lin, 32'd4096, 32'd4096));
	endfunction

	function automatic tone_t map_pixel(input pixel_t px);
		tone_t o;
		o.r = map_channel(px.r);
		o.g = map_channel(px.g);
		o.b = map_channel(px.b);
		o.a = (mdl_mode == MODE_HDR) ? HALF_ONE : 16'd0;
		o.eof = px.eof;
		return o;
	endfunction

	initial begin
		clk = 0;
		forever #10 clk = ~clk;
	end

	// Driver: one word per accepted start.
	always @(posedge clk) begin
		if (start && !busy) begin
			tone_queue.insert(tone_queue.size(),
				map_pixel({red_in, green_in, blue_in, end_of_frame}));
			accepted_in++;
			if (mdl_mode == MODE_HDR)
				hdr_words++;
			else
				srgb_words++;
		end
		if (feed_on && pixel_queue.size() > 0 && $urandom_range(99) >= idle_pct &&
				!(start && !busy && pixel_queue.size() == 0)) begin
			pixel_t px;
			px = pixel_queue.pop_front();
			start <= 1'b1;
			red_in <= px.r;
			green_in <= px.g;
			blue_in <= px.b;
			end_of_frame <= px.eof;
		end else if (start && !busy) begin
			start <= 1'b0;
		end
	end

	// Monitor and watchdog.
	always @(posedge clk) begin
		if (strobe) begin
			tone_t exp_w, got;
			got = {red_out, green_out, blue_out, alpha_out, frame_done};
			accepted_out++;
			if (tone_queue.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected word %h", got);
			end else begin
				exp_w = tone_queue.pop_front();
				if (got !== exp_w) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: exp r=%h g=%h b=%h a=%h f=%b got r=%h g=%h b=%h a=%h f=%b",
							exp_w.r, exp_w.g, exp_w.b, exp_w.a, exp_w.eof,
							got.r, got.g, got.b, got.a, got.eof);
				end
			end
		end
		if (strobe || (start && !busy) || (psel && penable))
			wdog = 0;
		else
			wdog++;
		if (wdog >= WDOG_MAX) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	task automatic reg_write(input logic [3:0] addr, input logic [31:0] val);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (addr)
			ADDR_MODE: mdl_mode = val[0];
			ADDR_GAIN: mdl_gain = val[15:0];
			ADDR_HEAD: mdl_head = val[15:0];
			default: ;
		endcase
	endtask

	task automatic drain();
		while (pixel_queue.size() > 0 || start || tone_queue.size() > 0)
			@(posedge clk);
		repeat (LATENCY) @(posedge clk);
	endtask

	function automatic logic [INPUT_WIDTH-1:0] rand_lin();
		case ($urandom_range(4))
			0: return INPUT_WIDTH'($urandom_range(2000));
			1: return INPUT_WIDTH'($urandom_range(70000));
			2: return INPUT_WIDTH'($urandom_range(300000));
			default: return INPUT_WIDTH'($urandom);
		endcase
	endfunction

	task automatic add_pixel(input logic [INPUT_WIDTH-1:0] r, g, b, input logic eof);
		pixel_queue.insert(pixel_queue.size(), {r, g, b, eof});
	endtask

	task automatic run_random(input int count, input int pct);
		idle_pct = pct;
		for (int i = 0; i < count; i++)
			add_pixel(rand_lin(), rand_lin(), rand_lin(), ($urandom_range(15) == 0));
		drain();
	endtask

	initial begin
		logic [15:0] gains[4];
		logic [15:0] heads[4];
		gains = '{16'd4096, 16'd0, 16'hFFFF, 16'd9000};
		heads = '{16'd4096, 16'd0, 16'd40, 16'hFFFF};
		arst_n = 0;
		psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
		start = 0; red_in = '0; green_in = '0; blue_in = '0; end_of_frame = 0;
		mdl_mode = MODE_SRGB; mdl_gain = 16'd4096; mdl_head = 16'd4096;
		mismatches = 0; accepted_in = 0; accepted_out = 0; wdog = 0;
		hdr_words = 0; srgb_words = 0;
		idle_pct = 0; feed_on = 0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed words: zero, pass-through edge, sRGB linear segment, extremes.
		feed_on = 1;
		for (int m = 0; m < 2; m++) begin
			reg_write(ADDR_MODE, m ? 32'(MODE_HDR) : 32'(MODE_SRGB));
			add_pixel('0, 20'd1310, 20'd1311, 1'b0);
			add_pixel(20'd205, 20'd206, 20'd65536, 1'b1);
			add_pixel('1, 20'd3, 20'd4, 1'b0);
			add_pixel(20'hAAAAA, 20'h55555, 20'd1000, 1'b1);
			drain();
		end
		reg_write(ADDR_GAIN, 32'd0);
		add_pixel('1, 20'd5000, 20'd1, 1'b1);
		drain();
		reg_write(ADDR_GAIN, 32'hFFFF);
		reg_write(ADDR_HEAD, 32'd0);
		add_pixel('1, 20'd5000, 20'd1, 1'b0);
		drain();
		reg_write(ADDR_HEAD, 32'd40);
		add_pixel('1, 20'd300, 20'd20, 1'b1);
		drain();

		// Random phases across register settings and idle patterns.
		for (int ph = 0; ph < 8; ph++) begin
			reg_write(ADDR_MODE, 32'(ph[0]));
			reg_write(ADDR_GAIN, (ph < 4) ? 32'(gains[ph]) : $urandom);
			reg_write(ADDR_HEAD, (ph < 4) ? 32'(heads[ph]) : $urandom);
			case (ph % 4)
				0: run_random(220, 0);
				1: run_random(220, 57);
				2: run_random(220, 15);
				default: run_random(220, 0);
			endcase
		end
		feed_on = 0;
		drain();

		$display("words in %0d, out %0d (sRGB %0d, HDR %0d) over gain and headroom extremes",
			accepted_in, accepted_out, srgb_words, hdr_words);
		if (mismatches == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("mismatches: %0d", mismatches);
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule
